>>> hdl/sam_pkg.sv
// Shared constants for the segmentation argmax mask block.
// Used by sam_rem_step and segmentation_argmax_mask_top; depends on nothing.
package sam_pkg;

  // Configuration port geometry.
  localparam int CfgDataWidth  = 32;
  localparam int CfgIndexWidth = 3;

  // Register indexes on the configuration port.
  localparam logic [CfgIndexWidth-1:0] RegThreshold  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegBackground = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegNumChan    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegFrameWidth = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegFrameHeight = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegStepSize   = 3'd5;

  // Field and register widths that do not vary.
  localparam int ClassWidth   = 8;
  localparam int ChanWidth    = 8;
  localparam int DimCfgWidth  = 13;
  localparam int StepWidth    = 5;

  // Class code given when no channel beats the threshold.
  localparam logic [ClassWidth-1:0] NoClass = 8'd255;

endpackage

>>> hdl/segmentation_argmax_mask_top.sv
// Top level of the segmentation argmax mask block.
// Depends on sam_pkg and sam_rem_step.
//
// The block takes a score tensor in channel-interleaved order, one score per
// transfer, and gives one class index per kept pixel: the first channel whose
// score strictly exceeds both the threshold and every earlier channel, or 255
// when none does; in background mode channel 0 is never chosen. A pixel is
// kept when its row and column are multiples of the step and lie inside the
// largest multiple of the step that fits the frame. The block accepts one
// score every clock cycle with no gaps while the output side keeps taking
// results. When the output side stalls, the waiting result stays in the output
// register and scores keep flowing until the next pixel's last channel has
// been taken into the snapshot stage (every pixel passes that stage, kept or
// not); the input then stalls until the waiting result leaves. Each result
// passes the snapshot stage, which holds the counter snapshot, and then the
// output register; the divisibility test by the step runs as a short restoring
// remainder split over the two. Configuration is to be written through a plain
// write port while the stream is idle; the block does not enforce this. Zero in
// a size register acts as one, and frame sizes above MAX_DIM act as MAX_DIM.
module segmentation_argmax_mask_top #(
  parameter int SCORE_WIDTH = 32,
  parameter int MAX_DIM     = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port.
  input  logic                                   cfg_we_i,
  input  logic [sam_pkg::CfgIndexWidth-1:0]      cfg_index_i,
  input  logic [sam_pkg::CfgDataWidth-1:0]       cfg_data_i,
  // Score stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SCORE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,   // [SCORE_WIDTH-1:0] score
  // Class stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [sam_pkg::ClassWidth-1:0]         m_axis_tdata,   // [7:0] class_index
  output logic                                   m_axis_tlast,   // end_of_row
  output logic [0:0]                             m_axis_tuser    // [0] end_of_frame
);

  // Counter width holds positions below MAX_DIM; dimension width holds MAX_DIM.
  localparam int CntW = $clog2(MAX_DIM);
  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int SumW = DimW + 2;
  // The remainder of a position by the step is built in two halves.
  localparam int LoW  = CntW / 2;
  localparam int HiW  = CntW - LoW;

  localparam int SW = sam_pkg::StepWidth;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic signed [SCORE_WIDTH-1:0]       thr_q;
  logic                                bg_q;
  logic [sam_pkg::ChanWidth-1:0]       nchan_q;
  logic [sam_pkg::DimCfgWidth-1:0]     fwidth_q;
  logic [sam_pkg::DimCfgWidth-1:0]     fheight_q;
  logic [SW-1:0]                       step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      bg_q      <= 1'b0;
      nchan_q   <= sam_pkg::ChanWidth'(1);
      fwidth_q  <= sam_pkg::DimCfgWidth'(1);
      fheight_q <= sam_pkg::DimCfgWidth'(1);
      step_q    <= SW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sam_pkg::RegThreshold:   thr_q     <= signed'(cfg_data_i[SCORE_WIDTH-1:0]);
        sam_pkg::RegBackground:  bg_q      <= cfg_data_i[0];
        sam_pkg::RegNumChan:     nchan_q   <= cfg_data_i[sam_pkg::ChanWidth-1:0];
        sam_pkg::RegFrameWidth:  fwidth_q  <= cfg_data_i[sam_pkg::DimCfgWidth-1:0];
        sam_pkg::RegFrameHeight: fheight_q <= cfg_data_i[sam_pkg::DimCfgWidth-1:0];
        sam_pkg::RegStepSize:    step_q    <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, frame sizes are clamped to MAX_DIM.
  logic [sam_pkg::ChanWidth-1:0] nchan_eff;
  logic [DimW-1:0]               width_eff;
  logic [DimW-1:0]               height_eff;
  logic [SW-1:0]                 step_eff;

  assign nchan_eff  = (nchan_q == '0) ? sam_pkg::ChanWidth'(1) : nchan_q;
  assign step_eff   = (step_q == '0) ? SW'(1) : step_q;
  assign width_eff  = (fwidth_q == '0) ? DimW'(1) :
                      (32'(fwidth_q) > MAX_DIM) ? DimW'(MAX_DIM) : DimW'(fwidth_q);
  assign height_eff = (fheight_q == '0) ? DimW'(1) :
                      (32'(fheight_q) > MAX_DIM) ? DimW'(MAX_DIM) : DimW'(fheight_q);

  // ---------------------------------------------------------------------------
  // Handshake. Each stage takes new data when it is empty or drains onward.
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic s1_valid_q;
  logic out_ready;
  logic s1_ready;
  logic in_xfer;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Channel argmax and position counters.
  // ---------------------------------------------------------------------------
  logic [sam_pkg::ChanWidth-1:0]  chan_q,  chan_d;
  logic [CntW-1:0]                col_q,   col_d;
  logic [CntW-1:0]                row_q,   row_d;
  logic signed [SCORE_WIDTH-1:0]  best_score_q, best_score_d;
  logic [sam_pkg::ClassWidth-1:0] best_class_q, best_class_d;

  logic signed [SCORE_WIDTH-1:0]  score;
  logic                           last_chan;
  logic                           above_thr;

  assign score     = signed'(s_axis_tdata[SCORE_WIDTH-1:0]);
  assign last_chan = chan_q >= (nchan_eff - sam_pkg::ChanWidth'(1));
  assign above_thr = score > thr_q;

  always_comb begin
    best_score_d = best_score_q;
    best_class_d = best_class_q;
    if (chan_q == '0) begin
      // First channel restarts the search from the threshold. In background
      // mode channel 0 only raises the bar and is never chosen.
      best_score_d = above_thr ? score : thr_q;
      best_class_d = (above_thr && !bg_q) ? '0 : sam_pkg::NoClass;
    end else if (score > best_score_q) begin
      best_score_d = score;
      best_class_d = chan_q;
    end
  end

  always_comb begin
    chan_d = chan_q;
    col_d  = col_q;
    row_d  = row_q;
    if (last_chan) begin
      chan_d = '0;
      if (DimW'(col_q) >= width_eff - DimW'(1)) begin
        col_d = '0;
        if (DimW'(row_q) >= height_eff - DimW'(1)) begin
          row_d = '0;
        end else begin
          row_d = row_q + CntW'(1);
        end
      end else begin
        col_d = col_q + CntW'(1);
      end
    end else begin
      chan_d = chan_q + sam_pkg::ChanWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (in_xfer) begin
      chan_q <= chan_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      best_score_q <= best_score_d;
      best_class_q <= best_class_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Keep test, first half. For a position p that is a multiple of the step,
  // p lies inside the kept range when p + step <= size, and p is the last kept
  // one when p + 2 * step > size. Divisibility comes from a remainder whose
  // upper bits are folded here and lower bits in the next stage.
  // ---------------------------------------------------------------------------
  logic [SumW-1:0] step_sum;
  logic [SumW-1:0] step_dbl;
  logic            col_fits, col_last, row_fits, row_last;
  logic [SW-1:0]   col_rem_hi, row_rem_hi;

  assign step_sum = SumW'(step_eff);
  assign step_dbl = SumW'({step_eff, 1'b0});
  assign col_fits = SumW'(col_q) + step_sum <= SumW'(width_eff);
  assign col_last = SumW'(col_q) + step_dbl >  SumW'(width_eff);
  assign row_fits = SumW'(row_q) + step_sum <= SumW'(height_eff);
  assign row_last = SumW'(row_q) + step_dbl >  SumW'(height_eff);

  sam_rem_step #(.NumBits(HiW)) u_col_hi (
    .divisor_i (step_eff),
    .rem_i     ('0),
    .bits_i    (col_q[CntW-1:LoW]),
    .rem_o     (col_rem_hi)
  );

  sam_rem_step #(.NumBits(HiW)) u_row_hi (
    .divisor_i (step_eff),
    .rem_i     ('0),
    .bits_i    (row_q[CntW-1:LoW]),
    .rem_o     (row_rem_hi)
  );

  // Snapshot stage, loaded at the last channel of every pixel.
  logic [sam_pkg::ClassWidth-1:0] s1_class_q;
  logic [SW-1:0]                  s1_step_q;
  logic [SW-1:0]                  s1_col_rem_q, s1_row_rem_q;
  logic [LoW-1:0]                 s1_col_lo_q,  s1_row_lo_q;
  logic                           s1_col_fits_q, s1_col_last_q;
  logic                           s1_row_fits_q, s1_row_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_xfer && last_chan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_xfer && last_chan) begin
      s1_class_q    <= best_class_d;
      s1_step_q     <= step_eff;
      s1_col_rem_q  <= col_rem_hi;
      s1_row_rem_q  <= row_rem_hi;
      s1_col_lo_q   <= col_q[LoW-1:0];
      s1_row_lo_q   <= row_q[LoW-1:0];
      s1_col_fits_q <= col_fits;
      s1_col_last_q <= col_last;
      s1_row_fits_q <= row_fits;
      s1_row_last_q <= row_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Keep test, second half, and the output register.
  // ---------------------------------------------------------------------------
  logic [SW-1:0] col_rem, row_rem;
  logic          kept;

  sam_rem_step #(.NumBits(LoW)) u_col_lo (
    .divisor_i (s1_step_q),
    .rem_i     (s1_col_rem_q),
    .bits_i    (s1_col_lo_q),
    .rem_o     (col_rem)
  );

  sam_rem_step #(.NumBits(LoW)) u_row_lo (
    .divisor_i (s1_step_q),
    .rem_i     (s1_row_rem_q),
    .bits_i    (s1_row_lo_q),
    .rem_o     (row_rem)
  );

  assign kept = (col_rem == '0) && (row_rem == '0) && s1_col_fits_q && s1_row_fits_q;

  logic [sam_pkg::ClassWidth-1:0] out_class_q;
  logic                           out_eor_q;
  logic                           out_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q && kept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q && kept) begin
      out_class_q <= s1_class_q;
      out_eor_q   <= s1_col_last_q;
      out_eof_q   <= s1_col_last_q && s1_row_last_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_class_q;
  assign m_axis_tlast    = out_eor_q;
  assign m_axis_tuser[0] = out_eof_q;

endmodule

>>> hdl/sam_rem_step.sv
// A few restoring-division steps that fold numerator bits into a remainder.
// Depends on sam_pkg for the step width.
module sam_rem_step #(
  parameter int NumBits = 6
) (
  input  logic [sam_pkg::StepWidth-1:0] divisor_i,
  input  logic [sam_pkg::StepWidth-1:0] rem_i,
  input  logic [NumBits-1:0]            bits_i,
  output logic [sam_pkg::StepWidth-1:0] rem_o
);

  always_comb begin
    logic [sam_pkg::StepWidth:0]   acc;
    logic [sam_pkg::StepWidth-1:0] r;
    r   = rem_i;
    acc = '0;
    for (int i = NumBits - 1; i >= 0; i--) begin
      acc = {r, bits_i[i]};
      // The remainder stays below the divisor, so one subtract suffices.
      if (acc >= {1'b0, divisor_i}) begin
        acc = acc - {1'b0, divisor_i};
      end
      r = acc[sam_pkg::StepWidth-1:0];
    end
    rem_o = r;
  end

endmodule

>>> tb/segmentation_argmax_mask_top_test.sv
// Self-checking testbench for segmentation_argmax_mask_top: scores are streamed in
// channel-interleaved order and every class transfer is checked against a predictor.
// Depends on sam_pkg and the RTL of segmentation_argmax_mask_top only.
`timescale 1ns / 100ps

module segmentation_argmax_mask_top_test;

  localparam int ScoreWidth = 32;
  localparam int MaxDim = 4096;
  // A result passes the snapshot and then the output register after its last
  // channel; the settle time before a register write adds a margin to that.
  localparam int ResultLatency = 2;
  localparam int SettleCycles = ResultLatency + 4;
  localparam int RandomItems = 1280;

  // One expected class transfer.
  typedef struct packed {
    logic [sam_pkg::ClassWidth-1:0] class_index;
    logic                           end_of_row;
    logic                           end_of_frame;
  } mask_px_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [sam_pkg::CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [sam_pkg::CfgDataWidth-1:0]  cfg_data_i = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [ScoreWidth-1:0]             s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [sam_pkg::ClassWidth-1:0]    m_axis_tdata;
  logic                              m_axis_tlast;
  logic [0:0]                        m_axis_tuser;

  segmentation_argmax_mask_top #(
    .SCORE_WIDTH(ScoreWidth),
    .MAX_DIM    (MaxDim)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [31:0] score
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [7:0] class_index
    .m_axis_tlast (m_axis_tlast),   // end_of_row
    .m_axis_tuser (m_axis_tuser)    // [0] end_of_frame
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the configuration registers, as written (already cut to width).
  logic signed [31:0]              cfg_threshold = '0;
  logic                            cfg_background = 1'b0;
  logic [sam_pkg::ChanWidth-1:0]   cfg_num_chan = 8'd1;
  logic [sam_pkg::DimCfgWidth-1:0] cfg_width = 13'd1;
  logic [sam_pkg::DimCfgWidth-1:0] cfg_height = 13'd1;
  logic [sam_pkg::StepWidth-1:0]   cfg_step = 5'd1;

  // Mirror of the block's scan position and running maximum.
  logic [sam_pkg::ChanWidth-1:0]   px_chan = '0;
  logic [sam_pkg::DimCfgWidth-1:0] px_col = '0;
  logic [sam_pkg::DimCfgWidth-1:0] px_row = '0;
  logic signed [31:0]              run_best_score = '0;
  logic [sam_pkg::ClassWidth-1:0]  run_best_class = sam_pkg::NoClass;

  mask_px_t    mask_pixels_due[$];
  mask_px_t    due_px;
  int unsigned mismatches = 0;
  // When clear, neither side of the stream inserts gaps or stalls.
  bit          idle_on = 1'b1;

  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned frame_dim(logic [sam_pkg::DimCfgWidth-1:0] v);
    int unsigned d;
    d = at_least_one(v);
    return (d > MaxDim) ? MaxDim : d;
  endfunction

  // Advances the predicted scan by one accepted score and queues the class
  // transfer when the score closes a kept pixel.
  task automatic predict_mask_pixel(logic [31:0] raw);
    logic signed [31:0] v;
    int unsigned        nc, w, h, st, kept_w, kept_h;
    bit                 last_ch, kept, eor;
    mask_px_t           px;
    v = raw;
    nc = at_least_one(cfg_num_chan);
    w = frame_dim(cfg_width);
    h = frame_dim(cfg_height);
    st = at_least_one(cfg_step);
    kept_w = (w / st) * st;
    kept_h = (h / st) * st;
    last_ch = (px_chan >= nc - 1);

    // Threshold and background mode only take effect at channel 0.
    if (px_chan == 0) begin
      run_best_class = sam_pkg::NoClass;
      if (cfg_background) begin
        run_best_score = (v > cfg_threshold) ? v : cfg_threshold;
      end else begin
        run_best_score = cfg_threshold;
        if (v > run_best_score) begin
          run_best_score = v;
          run_best_class = '0;
        end
      end
    end else if (v > run_best_score) begin
      run_best_score = v;
      run_best_class = px_chan;
    end

    if (last_ch) begin
      kept = (px_col % st == 0) && (px_row % st == 0) && (px_col < kept_w) &&
             (px_row < kept_h);
      if (kept) begin
        eor = (px_col + st >= kept_w);
        px.class_index = run_best_class;
        px.end_of_row = eor;
        px.end_of_frame = eor && (px_row + st >= kept_h);
        mask_pixels_due.push_back(px);
      end
      px_chan = '0;
      // Counters at or past their last value wrap, which also covers a
      // frame size that shrank while the scan was further along.
      if (px_col >= w - 1) begin
        px_col = '0;
        if (px_row >= h - 1) px_row = '0;
        else px_row = px_row + 1'b1;
      end else begin
        px_col = px_col + 1'b1;
      end
    end else begin
      px_chan = px_chan + 1'b1;
    end
  endtask

  // Class stream receiver: stalls at random while idling is on.
  always @(negedge clk_i) begin
    if (idle_on && $urandom_range(99) < 19) m_axis_tready <= 1'b0;
    else m_axis_tready <= 1'b1;
  end

  // Every class transfer is checked against the oldest expected pixel.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mask_pixels_due.size() == 0) begin
        $error("class transfer with no pixel pending: class_index %0d", m_axis_tdata);
        mismatches++;
      end else begin
        due_px = mask_pixels_due.pop_front();
        if (m_axis_tdata !== due_px.class_index) begin
          $error("class_index: expected %0d, actual %0d", due_px.class_index, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== due_px.end_of_row) begin
          $error("end_of_row: expected %0b, actual %0b", due_px.end_of_row, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser[0] !== due_px.end_of_frame) begin
          $error("end_of_frame: expected %0b, actual %0b", due_px.end_of_frame,
                 m_axis_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // All tasks below start and end at a falling edge.

  // Sends one score; the prediction is made at the edge of the transfer.
  task automatic send_score(logic [31:0] score);
    while (idle_on && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= score;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_mask_pixel(score);
    @(negedge clk_i);
  endtask

  // Holds the score stream until every expected class transfer has arrived.
  task automatic pause_for_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (mask_pixels_due.size() != 0) @(negedge clk_i);
  endtask

  // Brings the block to rest: a pixel that is not kept gives no result, so
  // a few more cycles pass after the last expected one.
  task automatic settle();
    pause_for_results();
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes one register; only called while the block is at rest.
  task automatic write_reg(logic [sam_pkg::CfgIndexWidth-1:0] index, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (index)
      sam_pkg::RegThreshold:   cfg_threshold = data;
      sam_pkg::RegBackground:  cfg_background = data[0];
      sam_pkg::RegNumChan:     cfg_num_chan = data[sam_pkg::ChanWidth-1:0];
      sam_pkg::RegFrameWidth:  cfg_width = data[sam_pkg::DimCfgWidth-1:0];
      sam_pkg::RegFrameHeight: cfg_height = data[sam_pkg::DimCfgWidth-1:0];
      sam_pkg::RegStepSize:    cfg_step = data[sam_pkg::StepWidth-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_geometry(int unsigned nc, int unsigned w, int unsigned h,
                                int unsigned st);
    write_reg(sam_pkg::RegNumChan, nc);
    write_reg(sam_pkg::RegFrameWidth, w);
    write_reg(sam_pkg::RegFrameHeight, h);
    write_reg(sam_pkg::RegStepSize, st);
  endtask

  // Returns every counter to zero: with a one-pixel, one-channel frame the
  // next score wraps them all.
  task automatic rewind_scan();
    settle();
    write_geometry(1, 1, 1, 1);
    send_score($urandom);
    settle();
  endtask

  // Reset values give a single-pixel frame: each score is its own mask.
  task automatic test_reset_values();
    send_score(32'd0);
    send_score(32'd1);
    send_score(32'hFFFF_FFFF);
    send_score(32'h7FFF_FFFF);
    send_score(32'h8000_0000);
  endtask

  // Thresholds at both ends of the range, plus a tie that must keep the
  // earlier channel.
  task automatic test_threshold_extremes();
    settle();
    write_geometry(3, 2, 1, 1);
    write_reg(sam_pkg::RegThreshold, 32'h7FFF_FFFF);
    send_score(32'h7FFF_FFFF);
    send_score(32'h7FFF_FFFF);
    send_score(32'h8000_0000);
    settle();
    write_reg(sam_pkg::RegThreshold, 32'h8000_0000);
    send_score(32'h8000_0000);
    send_score(32'h8000_0000);
    send_score(32'h8000_0000);
    send_score(32'h8000_0001);
    send_score(32'd9);
    send_score(32'd9);
  endtask

  // Background mode: channel 0 only lifts the starting best.
  task automatic test_background();
    settle();
    write_reg(sam_pkg::RegThreshold, 32'd0);
    write_reg(sam_pkg::RegBackground, 32'd1);
    write_reg(sam_pkg::RegNumChan, 32'd1);
    send_score(32'd100);
    send_score(32'hFFFF_FFFB);
    settle();
    write_reg(sam_pkg::RegNumChan, 32'd3);
    send_score(32'd50);
    send_score(32'd40);
    send_score(32'd60);
    send_score(32'd50);
    send_score(32'd50);
    send_score(32'd50);
    send_score(32'hFFFF_FFFB);
    send_score(32'hFFFF_FFF6);
    send_score(32'd1);
    settle();
    write_reg(sam_pkg::RegBackground, 32'd0);
  endtask

  // Zero in a size register acts as one.
  task automatic test_zero_sizes();
    settle();
    write_geometry(0, 0, 0, 0);
    send_score(32'd3);
    send_score(32'hFFFF_FFFF);
    send_score(32'd0);
  endtask

  // A step beyond the frame keeps no pixel at all.
  task automatic test_step_beyond_frame();
    rewind_scan();
    write_geometry(1, 3, 2, 5);
    repeat (6) send_score($urandom);
    settle();
    write_reg(sam_pkg::RegStepSize, 32'd31);
    repeat (3) send_score($urandom);
  endtask

  // Registers change while the scan sits in the middle of a pixel and a row.
  task automatic test_config_mid_pixel();
    rewind_scan();
    write_geometry(4, 3, 2, 1);
    send_score(32'd5);
    send_score(32'd7);
    settle();
    // The channel counter is already past the new last channel.
    write_reg(sam_pkg::RegNumChan, 32'd2);
    write_reg(sam_pkg::RegThreshold, 32'd100);
    send_score(32'd8);
    settle();
    // The column counter is now beyond the narrower row.
    write_reg(sam_pkg::RegFrameWidth, 32'd1);
    send_score(32'd200);
    send_score(32'd150);
    send_score(32'd300);
    send_score(32'd99);
  endtask

  // An oversized width acts as the largest frame; the start of such a row
  // is scanned with a step of 16.
  task automatic test_largest_frame();
    rewind_scan();
    write_reg(sam_pkg::RegThreshold, 32'd0);
    write_geometry(1, 8191, MaxDim, 16);
    repeat (160) send_score($urandom_range(8) - 4);
  endtask

  // The most channels per pixel, two pixels to a frame.
  task automatic test_most_channels();
    rewind_scan();
    write_geometry(255, 2, 1, 1);
    repeat (2 * 255) send_score($urandom_range(40) - 20);
  endtask

  function automatic logic [31:0] random_score();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return cfg_threshold + $urandom_range(6) - 3;
      5, 6:          return $urandom_range(8) - 4;
      7:             return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default:       return $urandom;
    endcase
  endfunction

  function automatic int unsigned random_dim();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return 0;
    if (pick < 10) return $urandom_range(8191, 4090);
    return $urandom_range(9, 1);
  endfunction

  // Writes a random subset of the registers; unused upper bits of the write
  // data carry noise now and then.
  task automatic pick_random_settings();
    logic [31:0] noise;
    int unsigned pick, value;
    noise = ($urandom_range(3) == 0) ? $urandom : 32'd0;
    if ($urandom_range(99) < 70) begin
      case ($urandom_range(5))
        0:       write_reg(sam_pkg::RegThreshold, 32'h8000_0000);
        1:       write_reg(sam_pkg::RegThreshold, 32'h7FFF_FFFF);
        2, 3:    write_reg(sam_pkg::RegThreshold, $urandom_range(16) - 8);
        default: write_reg(sam_pkg::RegThreshold, $urandom);
      endcase
    end
    if ($urandom_range(99) < 50)
      write_reg(sam_pkg::RegBackground, (noise << 1) | ($urandom_range(99) < 30));
    if ($urandom_range(99) < 70) begin
      pick = $urandom_range(99);
      if (pick < 8) value = 0;
      else if (pick < 20) value = $urandom_range(24, 6);
      else if (pick < 25) value = 255;
      else value = $urandom_range(5, 1);
      write_reg(sam_pkg::RegNumChan, (noise << sam_pkg::ChanWidth) | value);
    end
    if ($urandom_range(99) < 70)
      write_reg(sam_pkg::RegFrameWidth, (noise << sam_pkg::DimCfgWidth) | random_dim());
    if ($urandom_range(99) < 70)
      write_reg(sam_pkg::RegFrameHeight, (noise << sam_pkg::DimCfgWidth) | random_dim());
    if ($urandom_range(99) < 70) begin
      pick = $urandom_range(99);
      if (pick < 8) value = 0;
      else if (pick < 16) value = $urandom_range(31, 5);
      else value = $urandom_range(4, 1);
      write_reg(sam_pkg::RegStepSize, (noise << sam_pkg::StepWidth) | value);
    end
  endtask

  // Random phases: new settings at rest, then a burst of scores. Some
  // phases run with no gaps or stalls but the rare pause for results.
  task automatic test_random_stream();
    int unsigned sent, phase, burst;
    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      settle();
      pick_random_settings();
      idle_on = !(phase == 3 || $urandom_range(99) < 10);
      burst = (phase == 3) ? 300 : $urandom_range(120, 10);
      repeat (burst) begin
        if ($urandom_range(99) == 0) pause_for_results();
        send_score(random_score());
      end
      sent += burst;
      phase++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_threshold_extremes();
    test_background();
    test_zero_sizes();
    test_step_beyond_frame();
    test_config_mid_pixel();
    test_largest_frame();
    test_most_channels();
    test_random_stream();
    settle();

    if (mismatches == 0) begin
      $display("PASS segmentation_argmax_mask_top");
    end else begin
      $display("FAIL segmentation_argmax_mask_top");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("FAIL segmentation_argmax_mask_top");
    $finish;
  end

endmodule

>>> filelist.f
hdl/sam_pkg.sv
hdl/sam_rem_step.sv
hdl/segmentation_argmax_mask_top.sv
tb/segmentation_argmax_mask_top_test.sv
